>>> src/dwsd_pkg.sv
// ----------------------------------------------------------------------------
// dwsd_pkg: shared types and constants of the debouncer
// Lane count, counter widths, register indexes and the lane result record.
// ----------------------------------------------------------------------------
package dwsd_pkg;

  localparam int LANE_COUNT   = 8;
  localparam int SETTLE_WIDTH = 8;
  localparam int HOLD_WIDTH   = 16;

  // Lanes that appear in the 8-bit port fields
  localparam int IO_LANES     = 8;

  localparam int DEBOUNCE_W   = 8;
  localparam int STUCK_W      = 16;
  localparam int MODE_W       = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  // Compare widths cover both the counter and its limit register
  localparam int SETTLE_CMP_W = (SETTLE_WIDTH > DEBOUNCE_W) ? SETTLE_WIDTH : DEBOUNCE_W;
  localparam int HOLD_CMP_W   = (HOLD_WIDTH > STUCK_W) ? HOLD_WIDTH : STUCK_W;

  localparam logic [MODE_W-1:0] SUPPRESS_MODE = 16'h00FF;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd10;
  localparam logic [STUCK_W-1:0]    STUCK_RESET    = 16'd3000;
  localparam logic [IO_LANES-1:0]   WATCH_RESET    = 8'h07;
  localparam logic [MODE_W-1:0]     MODE_RESET     = 16'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE_TICKS = 2'd0,
    REG_STUCK_TICKS    = 2'd1,
    REG_WATCH_MASK     = 2'd2,
    REG_NODE_MODE      = 2'd3
  } reg_index_t;

  // Limits every lane compares against
  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic [STUCK_W-1:0]    stuck_ticks;
  } lane_cfg_t;

  // What one lane found on the current word
  typedef struct packed {
    logic qual;
    logic changed;
    logic stuck_ev;
    logic rel_ev;
  } lane_res_t;

endpackage

>>> src/dwsd_lane.sv
// ----------------------------------------------------------------------------
// dwsd_lane: one debounce and stuck supervision lane
// Holds the settle and hold counters of one input and computes its update.
// ----------------------------------------------------------------------------
module dwsd_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  raw_bit,
  input  logic                  watch,
  input  dwsd_pkg::lane_cfg_t   cfg,
  output dwsd_pkg::lane_res_t   res
);

  logic                              candidate;
  logic                              candidate_next;
  logic [dwsd_pkg::SETTLE_WIDTH-1:0] settle;
  logic [dwsd_pkg::SETTLE_WIDTH-1:0] settle_next;
  logic [dwsd_pkg::HOLD_WIDTH-1:0]   hold;
  logic [dwsd_pkg::HOLD_WIDTH-1:0]   hold_next;
  logic                              stuck_mark;
  logic                              stuck_mark_next;
  logic                              qualified;
  logic                              qualified_next;

  logic                              lvl;
  logic                              hit;
  logic [dwsd_pkg::SETTLE_CMP_W-1:0] settle_ext;
  logic [dwsd_pkg::SETTLE_CMP_W-1:0] step_ext;
  logic [dwsd_pkg::SETTLE_CMP_W-1:0] limit_ext;
  logic [dwsd_pkg::HOLD_CMP_W-1:0]   hold_ext;
  logic [dwsd_pkg::HOLD_CMP_W-1:0]   stuck_ext;

  always_comb begin
    lvl = stuck_mark ? 1'b0 : raw_bit;

    settle_ext = '0;
    settle_ext[dwsd_pkg::SETTLE_WIDTH-1:0] = settle;
    limit_ext = '0;
    limit_ext[dwsd_pkg::DEBOUNCE_W-1:0] = cfg.debounce_ticks;

    candidate_next = candidate;
    settle_next    = settle;
    qualified_next = qualified;
    hit            = 1'b0;
    step_ext       = '0;

    if (lvl == candidate) begin
      if ((settle_ext < limit_ext) && (settle != '1)) begin
        settle_next = settle + 1'b1;
      end
      step_ext[dwsd_pkg::SETTLE_WIDTH-1:0] = settle_next;
      if (step_ext == limit_ext) begin
        // qualify, then park one above the limit (wraps at the counter top)
        hit            = 1'b1;
        settle_next    = settle_next + 1'b1;
        qualified_next = candidate;
      end
    end else begin
      settle_next    = '0;
      candidate_next = lvl;
    end
  end

  always_comb begin
    hold_ext = '0;
    hold_ext[dwsd_pkg::HOLD_WIDTH-1:0] = hold;
    stuck_ext = '0;
    stuck_ext[dwsd_pkg::STUCK_W-1:0] = cfg.stuck_ticks;

    hold_next       = hold;
    stuck_mark_next = stuck_mark;
    res.stuck_ev    = 1'b0;
    res.rel_ev      = 1'b0;

    if (watch) begin
      if (raw_bit) begin
        if (hold_ext < stuck_ext) begin
          // saturate at the counter top
          if (hold != '1) begin
            hold_next = hold + 1'b1;
          end
        end else begin
          res.stuck_ev    = !stuck_mark;
          stuck_mark_next = 1'b1;
        end
      end else begin
        res.rel_ev      = stuck_mark;
        stuck_mark_next = 1'b0;
        hold_next       = '0;
      end
    end else begin
      stuck_mark_next = 1'b0;
      hold_next       = '0;
    end

    res.qual    = qualified_next;
    res.changed = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate  <= 1'b0;
      settle     <= '0;
      hold       <= '0;
      stuck_mark <= 1'b0;
      qualified  <= 1'b0;
    end else if (accept) begin
      candidate  <= candidate_next;
      settle     <= settle_next;
      hold       <= hold_next;
      stuck_mark <= stuck_mark_next;
      qualified  <= qualified_next;
    end
  end

  a_unwatched_clear: assert property (@(posedge clk) disable iff (rst)
    accept && !watch |=> !stuck_mark && (hold == '0))
    else $error("unwatched lane kept stuck state");

  a_stuck_sets_mark: assert property (@(posedge clk) disable iff (rst)
    accept && res.stuck_ev |=> stuck_mark)
    else $error("stuck event without stuck mark");

  a_release_needs_mark: assert property (@(posedge clk) disable iff (rst)
    res.rel_ev |-> stuck_mark && !raw_bit)
    else $error("release event on a lane that is not stuck");

  a_no_double_event: assert property (@(posedge clk) disable iff (rst)
    !(res.stuck_ev && res.rel_ev))
    else $error("stuck and release on one word");

endmodule

>>> src/dwsd_merge.sv
// ----------------------------------------------------------------------------
// dwsd_merge: lane merge and output register
// Packs the lane results into one result word and holds it until taken.
// ----------------------------------------------------------------------------
module dwsd_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                suppress,
  input  dwsd_pkg::lane_res_t res [dwsd_pkg::LANE_COUNT],
  output logic                in_ready,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] debounced_bits, [8] changed_flag, [16:9] stuck_events,
  // [24:17] release_events, [31:25] zero
  output logic [31:0]         m_axis_tdata
);

  logic [dwsd_pkg::IO_LANES-1:0] deb_bits;
  logic [dwsd_pkg::IO_LANES-1:0] stuck_bits;
  logic [dwsd_pkg::IO_LANES-1:0] rel_bits;
  logic                          any_changed;
  logic [24:0]                   word;
  logic [24:0]                   data;

  for (genvar i = 0; i < dwsd_pkg::IO_LANES; i++) begin : g_pack
    if (i < dwsd_pkg::LANE_COUNT) begin : g_lane
      assign deb_bits[i]   = res[i].qual;
      assign stuck_bits[i] = res[i].stuck_ev && !suppress;
      assign rel_bits[i]   = res[i].rel_ev && !suppress;
    end else begin : g_none
      assign deb_bits[i]   = 1'b0;
      assign stuck_bits[i] = 1'b0;
      assign rel_bits[i]   = 1'b0;
    end
  end

  always_comb begin
    any_changed = 1'b0;
    for (int i = 0; i < dwsd_pkg::LANE_COUNT; i++) begin
      any_changed = any_changed | res[i].changed;
    end
    word = {rel_bits, stuck_bits, any_changed, deb_bits};
  end

  // take a new word when none is held or the held one leaves this cycle
  assign in_ready      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {7'd0, data};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (accept) begin
      data <= word;
    end
  end

  a_suppress_events: assert property (@(posedge clk) disable iff (rst)
    accept && suppress |=> (data[24:9] == '0))
    else $error("event reported while suppressed");

  a_valid_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted word not presented");

  a_change_flag: assert property (@(posedge clk) disable iff (rst)
    accept && !any_changed |=> $stable(data[7:0]))
    else $error("debounced bits moved without a qualify");

endmodule

>>> src/debounce_with_stuck_detect.sv
// ----------------------------------------------------------------------------
// debounce_with_stuck_detect: eight-input debouncer with stuck detection
// Per-lane settle and hold counters, merged into one result word per sample.
// ----------------------------------------------------------------------------
// Throughput: one sample word per cycle unless stalled; all lanes update in
// parallel in the accepting cycle, and the output register frees as its word
// is taken. A word's result is registered in the cycle after it is accepted.
// Reset: rst (synchronous) clears all lane counters, marks and debounced bits
// and loads the register defaults; no result word is pending after reset.
module debounce_with_stuck_detect (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] raw_inputs
  input  logic [7:0]                         s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] debounced_bits, [8] changed_flag, [16:9] stuck_events,
  // [24:17] release_events, [31:25] zero
  output logic [31:0]                        m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [dwsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dwsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  dwsd_pkg::lane_cfg_t              lane_cfg;
  logic [dwsd_pkg::IO_LANES-1:0]    watch_mask;
  logic [dwsd_pkg::MODE_W-1:0]      node_mode;
  logic                             accept;
  logic                             suppress;
  dwsd_pkg::lane_res_t              res [dwsd_pkg::LANE_COUNT];

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign suppress = (node_mode == dwsd_pkg::SUPPRESS_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_cfg.debounce_ticks <= dwsd_pkg::DEBOUNCE_RESET;
      lane_cfg.stuck_ticks    <= dwsd_pkg::STUCK_RESET;
      watch_mask              <= dwsd_pkg::WATCH_RESET;
      node_mode               <= dwsd_pkg::MODE_RESET;
    end else if (cfg_we) begin
      case (dwsd_pkg::reg_index_t'(cfg_index))
        dwsd_pkg::REG_DEBOUNCE_TICKS: begin
          lane_cfg.debounce_ticks <= cfg_data[dwsd_pkg::DEBOUNCE_W-1:0];
        end
        dwsd_pkg::REG_STUCK_TICKS: begin
          lane_cfg.stuck_ticks <= cfg_data[dwsd_pkg::STUCK_W-1:0];
        end
        dwsd_pkg::REG_WATCH_MASK: begin
          watch_mask <= cfg_data[dwsd_pkg::IO_LANES-1:0];
        end
        dwsd_pkg::REG_NODE_MODE: begin
          node_mode <= cfg_data[dwsd_pkg::MODE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < dwsd_pkg::LANE_COUNT; i++) begin : g_lane
    logic raw_bit;
    logic watch;

    // lanes past the port width sample low and are never watched
    if (i < dwsd_pkg::IO_LANES) begin : g_io
      assign raw_bit = s_axis_tdata[i];
      assign watch   = watch_mask[i];
    end else begin : g_idle
      assign raw_bit = 1'b0;
      assign watch   = 1'b0;
    end

    dwsd_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .accept  (accept),
      .raw_bit (raw_bit),
      .watch   (watch),
      .cfg     (lane_cfg),
      .res     (res[i])
    );
  end

  dwsd_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .suppress      (suppress),
    .res           (res),
    .in_ready      (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> tb/sv/tb_debounce_with_stuck_detect.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_debounce_with_stuck_detect: self-checking bench for the eight-lane debouncer
// Streams sample words under several register settings and idle patterns and
// compares every result word field by field against a cycle-free model of the
// settle counters, hold counters and stuck marks kept inside the bench.
// ----------------------------------------------------------------------------
module tb_debounce_with_stuck_detect;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_MAX     = (1 << dwsd_pkg::SETTLE_WIDTH) - 1;
  localparam int HOLD_MAX       = (1 << dwsd_pkg::HOLD_WIDTH) - 1;

  typedef struct packed {
    logic [6:0]                    pad;
    logic [dwsd_pkg::IO_LANES-1:0] release_events;
    logic [dwsd_pkg::IO_LANES-1:0] stuck_events;
    logic                          changed_flag;
    logic [dwsd_pkg::IO_LANES-1:0] debounced_bits;
  } tick_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic [7:0]                       s_tdata = '0;
  logic                             m_tready = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [dwsd_pkg::CFG_INDEX_W-1:0] cfg_index = dwsd_pkg::REG_DEBOUNCE_TICKS;
  logic [dwsd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             s_axis_tready;
  logic                             m_axis_tvalid;
  logic [31:0]                      m_axis_tdata;

  // Bench copy of the registers
  logic [dwsd_pkg::DEBOUNCE_W-1:0]  debounce_limit = dwsd_pkg::DEBOUNCE_RESET;
  logic [dwsd_pkg::STUCK_W-1:0]     stuck_limit    = dwsd_pkg::STUCK_RESET;
  logic [dwsd_pkg::IO_LANES-1:0]    watch_lanes    = dwsd_pkg::WATCH_RESET;
  logic [dwsd_pkg::MODE_W-1:0]      mode_reg       = dwsd_pkg::MODE_RESET;

  // Bench copy of the lane state
  logic [dwsd_pkg::LANE_COUNT-1:0]   qual_bits  = '0;
  logic [dwsd_pkg::LANE_COUNT-1:0]   cand_level = '0;
  logic [dwsd_pkg::LANE_COUNT-1:0]   stuck_lane = '0;
  logic [dwsd_pkg::SETTLE_WIDTH-1:0] settle_cnt [dwsd_pkg::LANE_COUNT];
  logic [dwsd_pkg::HOLD_WIDTH-1:0]   hold_cnt   [dwsd_pkg::LANE_COUNT];

  tick_result_t expected_ticks [$];
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           quiet_cycles = 0;

  logic [7:0] byte_list [8] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hFF, 8'h00};

  debounce_with_stuck_detect DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < dwsd_pkg::LANE_COUNT; i++) begin
      settle_cnt[i] = '0;
      hold_cnt[i]   = '0;
    end
  end

  // One sample tick of the debouncer and the stuck supervision
  function automatic tick_result_t debounce_tick(logic [7:0] raw);
    tick_result_t r;
    logic         lvl;
    int unsigned  c;
    r = '0;
    for (int i = 0; i < dwsd_pkg::LANE_COUNT; i++) begin
      lvl = stuck_lane[i] ? 1'b0 : raw[i];
      if (lvl == cand_level[i]) begin
        c = settle_cnt[i];
        if (c < debounce_limit && c < SETTLE_MAX) c++;
        if (c == debounce_limit) begin
          c = (c + 1) & SETTLE_MAX;
          qual_bits[i] = cand_level[i];
          r.changed_flag = 1'b1;
        end
        settle_cnt[i] = c[dwsd_pkg::SETTLE_WIDTH-1:0];
      end else begin
        settle_cnt[i] = '0;
        cand_level[i] = lvl;
      end
      if (watch_lanes[i]) begin
        if (raw[i]) begin
          if (hold_cnt[i] < stuck_limit) begin
            if (hold_cnt[i] < HOLD_MAX) hold_cnt[i] = hold_cnt[i] + 1'b1;
          end else begin
            if (!stuck_lane[i]) r.stuck_events[i] = 1'b1;
            stuck_lane[i] = 1'b1;
          end
        end else begin
          if (stuck_lane[i]) r.release_events[i] = 1'b1;
          stuck_lane[i] = 1'b0;
          hold_cnt[i]   = '0;
        end
      end else begin
        stuck_lane[i] = 1'b0;
        hold_cnt[i]   = '0;
      end
    end
    if (mode_reg == dwsd_pkg::SUPPRESS_MODE) begin
      r.stuck_events   = '0;
      r.release_events = '0;
    end
    r.debounced_bits = qual_bits[dwsd_pkg::IO_LANES-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check result words, then predict for the sample word taken at this edge
  always @(posedge clk) begin
    tick_result_t exp_r;
    tick_result_t got_r;
    if (!rst) begin
      if (m_axis_tvalid && m_tready) begin
        got_r = m_axis_tdata;
        if (expected_ticks.size() == 0) begin
          $error("result word 0x%08h with no expected word", m_axis_tdata);
          errors++;
        end else begin
          exp_r = expected_ticks.pop_front();
          if (got_r.debounced_bits !== exp_r.debounced_bits) begin
            $error("debounced_bits: expected 0x%02h, got 0x%02h",
                   exp_r.debounced_bits, got_r.debounced_bits);
            errors++;
          end
          if (got_r.changed_flag !== exp_r.changed_flag) begin
            $error("changed_flag: expected %0b, got %0b",
                   exp_r.changed_flag, got_r.changed_flag);
            errors++;
          end
          if (got_r.stuck_events !== exp_r.stuck_events) begin
            $error("stuck_events: expected 0x%02h, got 0x%02h",
                   exp_r.stuck_events, got_r.stuck_events);
            errors++;
          end
          if (got_r.release_events !== exp_r.release_events) begin
            $error("release_events: expected 0x%02h, got 0x%02h",
                   exp_r.release_events, got_r.release_events);
            errors++;
          end
          if (got_r.pad !== exp_r.pad) begin
            $error("pad: expected 0x%02h, got 0x%02h", exp_r.pad, got_r.pad);
            errors++;
          end
        end
      end
      if (s_tvalid && s_axis_tready) expected_ticks.push_back(debounce_tick(s_tdata));
    end
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_debounce_with_stuck_detect NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [7:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop valid and wait until every expected word is back and the pipe is empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_ticks.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Write all four registers; 8-bit registers get random upper data bits
  task automatic set_config(input logic [7:0] db, input logic [15:0] st,
                            input logic [7:0] wm, input logic [15:0] md);
    logic [dwsd_pkg::CFG_DATA_W-1:0] data [4];
    dwsd_pkg::reg_index_t            idx  [4];
    data[0] = {8'($urandom_range(255)), db};
    data[1] = st;
    data[2] = {8'($urandom_range(255)), wm};
    data[3] = md;
    idx[0]  = dwsd_pkg::REG_DEBOUNCE_TICKS;
    idx[1]  = dwsd_pkg::REG_STUCK_TICKS;
    idx[2]  = dwsd_pkg::REG_WATCH_MASK;
    idx[3]  = dwsd_pkg::REG_NODE_MODE;
    debounce_limit = db;
    stuck_limit    = st;
    watch_lanes    = wm;
    mode_reg       = md;
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= data[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Held levels with occasional bounce, plus a share of pure noise words
  task automatic run_phase(input logic [7:0] db, input logic [15:0] st,
                           input logic [7:0] wm, input logic [15:0] md,
                           input int n_words);
    int         sent;
    int         max_run;
    int         run_len;
    logic [7:0] base;
    logic [7:0] w;
    sent = 0;
    wait_idle();
    set_config(db, st, wm, md);
    max_run = db + ((st < 40) ? st : 40) + 4;
    if (max_run > 300) max_run = 300;
    while (sent < n_words) begin
      if ($urandom_range(9) == 0) begin
        send_word(8'($urandom_range(255)));
        sent++;
      end else begin
        base    = 8'($urandom_range(255));
        run_len = $urandom_range(1, max_run);
        for (int k = 0; k < run_len && sent < n_words; k++) begin
          w = base;
          if ($urandom_range(7) == 0) w = w ^ (8'h01 << $urandom_range(7));
          send_word(w);
          sent++;
        end
      end
    end
  endtask

  function automatic logic [15:0] pick_mode();
    return ($urandom_range(2) == 0) ? dwsd_pkg::SUPPRESS_MODE
                                    : 16'($urandom_range(65535));
  endfunction

  task automatic test_directed();
    // reset defaults first, no writes yet
    send_word(8'hFF);
    send_word(8'hFF);
    // zero settle and zero stuck limit: qualify and mark stuck at once
    wait_idle();
    set_config(8'd0, 16'd0, 8'h0F, 16'd0);
    foreach (byte_list[k]) send_word(byte_list[k]);
    // suppressed reporting on all lanes
    wait_idle();
    set_config(8'd3, 16'd2, 8'hFF, dwsd_pkg::SUPPRESS_MODE);
    repeat (5) send_word(8'hFF);
    repeat (2) send_word(8'h00);
    // settle limit of 254, no supervision
    wait_idle();
    set_config(8'd254, 16'hFFFF, 8'h00, dwsd_pkg::MODE_RESET);
    send_word(8'hFF);
    send_word(8'h80);
    send_word(8'h01);
    send_word(8'h00);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct  = 32;
    recv_stall_pct = 75;
    run_phase(8'd0, 16'd0, 8'hFF, 16'd0, 50);
    repeat (2) run_phase(8'($urandom_range(8)), 16'($urandom_range(24)),
                         8'($urandom_range(255)), pick_mode(), 50);
  endtask

  task automatic test_random_receiver_idle();
    send_idle_pct  = 75;
    recv_stall_pct = 32;
    run_phase(8'd2, 16'd6, 8'hFF, dwsd_pkg::SUPPRESS_MODE, 50);
    repeat (2) run_phase(8'($urandom_range(8)), 16'($urandom_range(24)),
                         8'($urandom_range(255)), pick_mode(), 50);
  endtask

  task automatic test_random_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(8'd1, 16'd3, 8'h00, 16'h01FF, 50);
    repeat (2) run_phase(8'($urandom_range(8)), 16'($urandom_range(24)),
                         8'($urandom_range(255)), pick_mode(), 50);
  endtask

  // Hold one level past a settle limit of 254, then bounce
  task automatic test_long_settle();
    wait_idle();
    set_config(8'd254, 16'hFFFF, 8'hFF, 16'hFFFF);
    repeat (258) send_word(8'hA5);
    repeat (20) send_word(8'($urandom_range(255)));
  endtask

  initial begin
    send_idle_pct  = 32;
    recv_stall_pct = 75;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_sender_idle();
    test_random_receiver_idle();
    test_random_no_idle();
    test_long_settle();
    wait_idle();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_debounce_with_stuck_detect OK");
    end else begin
      $display("tb_debounce_with_stuck_detect NOT OK");
    end
    $finish;
  end

endmodule

>>> debounce_with_stuck_detect.f
src/dwsd_pkg.sv
src/dwsd_lane.sv
src/dwsd_merge.sv
src/debounce_with_stuck_detect.sv
tb/sv/tb_debounce_with_stuck_detect.sv
